// ===== rtl/core/gsa_pkg.sv =====
package gsa_pkg;

  // Table geometry
  localparam int SLOTS     = 1024;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int HEAD_W    = IDX_W + 1;      // head/link also holds SLOTS ("empty")
  localparam int GEN_SHIFT = 12;
  localparam int HDL_W     = 31;
  localparam int TGT_W     = 10;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_DESTROY = 2'd2,
    CMD_RUN     = 2'd3
  } cmd_t;

  // Result codes
  typedef enum logic [1:0] {
    RC_OK      = 2'd0,
    RC_NO_FREE = 2'd1,
    RC_BAD     = 2'd2
  } rcode_t;

  // Slot status
  typedef enum logic [1:0] {
    SL_FREE     = 2'd0,
    SL_RUNNABLE = 2'd1,
    SL_RUNNING  = 2'd2
  } slot_st_t;

  // Controller states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FIX
  } fsm_state_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [HDL_W-1:0] handle;
    logic             check_perm;
    logic [HDL_W-1:0] parent_handle;
    logic [TGT_W-1:0] target_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       code;
    logic             has_slot;
    logic [TGT_W-1:0] slot_index;
    logic [HDL_W-1:0] slot_handle;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic clear;   // reset sweep write
    logic accept;  // input ready
    logic load;    // item taken, issue table reads
    logic commit;  // apply updates, load result register
    logic fix;     // demote previous running slot
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic need_fix;
  } dp_stat_t;

endpackage

// ===== rtl/core/gsa_if.sv =====
interface gsa_in_if;
  import gsa_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [HDL_W-1:0] handle;
  logic             check_perm;
  logic [HDL_W-1:0] parent_handle;
  logic [TGT_W-1:0] target_slot;

  modport source (output valid, cmd, handle, check_perm, parent_handle, target_slot,
                  input ready);
  modport sink (input valid, cmd, handle, check_perm, parent_handle, target_slot,
                output ready);
endinterface

interface gsa_out_if;
  import gsa_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       code;
  logic             has_slot;
  logic [TGT_W-1:0] slot_index;
  logic [HDL_W-1:0] slot_handle;

  modport source (output valid, code, has_slot, slot_index, slot_handle, input ready);
  modport sink (input valid, code, has_slot, slot_index, slot_handle, output ready);
endinterface

// ===== rtl/core/gsa_ctrl.sv =====
module gsa_ctrl
  import gsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  fsm_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) state_nxt = stat.need_fix ? S_FIX : S_IDLE;
      end
      S_FIX: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Command outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      S_CLEAR: begin
        ctl.clear = 1'b1;
      end
      S_IDLE: begin
        ctl.accept = 1'b1;
        ctl.load   = in_valid;
      end
      S_EXEC: begin
        ctl.commit = stat.out_free;
      end
      S_FIX: begin
        ctl.fix = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/gsa_dp.sv =====
module gsa_dp
  import gsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   ctl,
  input  in_item_t  in_item,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_item,
  output dp_stat_t  stat
);

  // Slot tables
  logic [HDL_W-1:0]  handle_mem [SLOTS];
  logic [1:0]        status_mem [SLOTS];
  logic [HDL_W-1:0]  parent_mem [SLOTS];
  logic [HEAD_W-1:0] next_mem   [SLOTS];

  // Latched item and registered read data
  cmd_t              cmd_r;
  logic [HDL_W-1:0]  handle_r;
  logic              perm_r;
  logic [HDL_W-1:0]  parent_r;
  logic [IDX_W-1:0]  tgt_r;
  logic [HDL_W-1:0]  rd_handle_r;
  slot_st_t          rd_status_r;
  logic [HDL_W-1:0]  rd_parent_r;
  logic [HEAD_W-1:0] rd_next_r;

  // Allocator state
  logic [HEAD_W-1:0] free_head_r, free_head_nxt;
  logic [IDX_W-1:0]  cur_slot_r, cur_slot_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [HDL_W-1:0]  cur_handle_r, cur_handle_nxt;
  logic [IDX_W-1:0]  fix_slot_r;
  logic [IDX_W-1:0]  clr_cnt_r;

  // Result register
  logic              out_valid_r;
  out_item_t         out_r;

  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  op_idx;
  logic [HDL_W:0]    gen_sum;
  logic [HDL_W:0]    gen_val;
  logic [HDL_W-1:0]  new_handle;
  logic              list_empty;
  logic              tgt_live;
  logic              need_fix;
  out_item_t         res;

  logic              ex_we_handle, ex_we_parent, ex_we_status, ex_we_next;
  slot_st_t          ex_status;

  logic              we_handle, we_status, we_next;
  logic [IDX_W-1:0]  wa_handle, wa_status, wa_next;
  logic [HDL_W-1:0]  wd_handle;
  logic [1:0]        wd_status;
  logic [HEAD_W-1:0] wd_next;

  // Read address for the incoming item
  always_comb begin
    case (cmd_t'(in_item.cmd))
      CMD_ALLOC:  rd_addr = free_head_r[IDX_W-1:0];
      CMD_LOOKUP: rd_addr = in_item.handle[IDX_W-1:0];
      default:    rd_addr = in_item.target_slot[IDX_W-1:0];
    endcase
  end

  // Item latch and table reads
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r       <= cmd_t'(in_item.cmd);
      handle_r    <= in_item.handle;
      perm_r      <= in_item.check_perm;
      parent_r    <= in_item.parent_handle;
      tgt_r       <= in_item.target_slot[IDX_W-1:0];
      rd_handle_r <= handle_mem[rd_addr];
      rd_status_r <= slot_st_t'(status_mem[rd_addr]);
      rd_parent_r <= parent_mem[rd_addr];
      rd_next_r   <= next_mem[rd_addr];
    end
  end

  // Next generation: add one generation step, drop index bits, restart on overflow
  always_comb begin
    gen_sum = {1'b0, rd_handle_r} + (HDL_W+1)'(1 << GEN_SHIFT);
    gen_val = gen_sum & ~(HDL_W+1)'(SLOTS - 1);
    if (gen_val[HDL_W]) gen_val = (HDL_W+1)'(1 << GEN_SHIFT);
    new_handle = gen_val[HDL_W-1:0] | HDL_W'(op_idx);
  end

  assign op_idx     = (cmd_r == CMD_ALLOC)  ? free_head_r[IDX_W-1:0] :
                      (cmd_r == CMD_LOOKUP) ? handle_r[IDX_W-1:0] : tgt_r;
  assign list_empty = (free_head_r >= HEAD_W'(SLOTS));
  assign tgt_live   = (rd_status_r != SL_FREE);

  // Command execution
  always_comb begin
    res            = '0;
    res.code       = RC_OK;
    ex_we_handle   = 1'b0;
    ex_we_parent   = 1'b0;
    ex_we_status   = 1'b0;
    ex_we_next     = 1'b0;
    ex_status      = SL_FREE;
    free_head_nxt  = free_head_r;
    cur_slot_nxt   = cur_slot_r;
    cur_valid_nxt  = cur_valid_r;
    cur_handle_nxt = cur_handle_r;
    need_fix       = 1'b0;
    case (cmd_r)
      CMD_ALLOC: begin
        if (list_empty) begin
          res.code = RC_NO_FREE;
        end else begin
          res.has_slot    = 1'b1;
          res.slot_index  = TGT_W'(op_idx);
          res.slot_handle = new_handle;
          ex_we_handle    = 1'b1;
          ex_we_parent    = 1'b1;
          ex_we_status    = 1'b1;
          ex_status       = SL_RUNNABLE;
          free_head_nxt   = rd_next_r;
        end
      end
      CMD_LOOKUP: begin
        if (handle_r == '0) begin
          // handle zero names the current slot
          if (cur_valid_r) begin
            res.has_slot    = 1'b1;
            res.slot_index  = TGT_W'(cur_slot_r);
            res.slot_handle = cur_handle_r;
          end
        end else if (!tgt_live || rd_handle_r != handle_r) begin
          res.code = RC_BAD;
        end else if (perm_r && (!cur_valid_r ||
                     (op_idx != cur_slot_r && rd_parent_r != cur_handle_r))) begin
          res.code = RC_BAD;
        end else begin
          res.has_slot    = 1'b1;
          res.slot_index  = TGT_W'(op_idx);
          res.slot_handle = rd_handle_r;
        end
      end
      CMD_DESTROY: begin
        if (!tgt_live) begin
          res.code = RC_BAD;
        end else begin
          res.has_slot    = 1'b1;
          res.slot_index  = TGT_W'(op_idx);
          res.slot_handle = rd_handle_r;
          ex_we_status    = 1'b1;
          ex_status       = SL_FREE;
          ex_we_next      = 1'b1;
          free_head_nxt   = HEAD_W'(op_idx);
          if (cur_valid_r && cur_slot_r == op_idx) cur_valid_nxt = 1'b0;
        end
      end
      CMD_RUN: begin
        if (!tgt_live) begin
          res.code = RC_BAD;
        end else begin
          res.has_slot    = 1'b1;
          res.slot_index  = TGT_W'(op_idx);
          res.slot_handle = rd_handle_r;
          ex_we_status    = 1'b1;
          ex_status       = SL_RUNNING;
          cur_slot_nxt    = op_idx;
          cur_valid_nxt   = 1'b1;
          cur_handle_nxt  = rd_handle_r;
          // the previous current slot is always running; demote it next cycle
          need_fix        = cur_valid_r && (cur_slot_r != op_idx);
        end
      end
      default: begin
        res.code = RC_BAD;
      end
    endcase
  end

  // Write port selection: reset sweep, then demotion, then command updates
  always_comb begin
    we_handle = 1'b0;
    wa_handle = op_idx;
    wd_handle = new_handle;
    we_status = 1'b0;
    wa_status = op_idx;
    wd_status = ex_status;
    we_next   = 1'b0;
    wa_next   = op_idx;
    wd_next   = free_head_r;
    if (ctl.clear) begin
      we_handle = 1'b1;
      wa_handle = clr_cnt_r;
      wd_handle = '0;
      we_status = 1'b1;
      wa_status = clr_cnt_r;
      wd_status = SL_FREE;
      we_next   = 1'b1;
      wa_next   = clr_cnt_r;
      wd_next   = HEAD_W'(clr_cnt_r) + HEAD_W'(1);
    end else if (ctl.fix) begin
      we_status = 1'b1;
      wa_status = fix_slot_r;
      wd_status = SL_RUNNABLE;
    end else if (ctl.commit) begin
      we_handle = ex_we_handle;
      we_status = ex_we_status;
      we_next   = ex_we_next;
    end
  end

  // Table writes
  always_ff @(posedge clk) begin
    if (we_handle) handle_mem[wa_handle] <= wd_handle;
  end

  always_ff @(posedge clk) begin
    if (we_status) status_mem[wa_status] <= wd_status;
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && ex_we_parent) parent_mem[op_idx] <= parent_r;
  end

  always_ff @(posedge clk) begin
    if (we_next) next_mem[wa_next] <= wd_next;
  end

  // Allocator state and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      if (ctl.clear) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (ctl.commit) begin
        free_head_r <= free_head_nxt;
        cur_slot_r  <= cur_slot_nxt;
        cur_valid_r <= cur_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      cur_handle_r <= cur_handle_nxt;
      fix_slot_r   <= cur_slot_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) out_r <= res;
  end

  assign out_valid     = out_valid_r;
  assign out_item      = out_r;
  assign stat.need_fix = need_fix;
  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.clr_last = (clr_cnt_r == IDX_W'(SLOTS - 1));

endmodule

// ===== rtl/core/generational_slot_allocator_top.sv =====
// Channel  Dir  Handshake           Item contents
// in_ch    in   valid/ready         cmd, handle, check_perm, parent_handle, target_slot
// out_ch   out  valid/ready         code, has_slot, slot_index, slot_handle
//
// Taking an item reads the slot tables; the execute state then updates them and
// loads the result register. Run adds a fix state when another slot was running,
// since the status table has one write port and both slots change status. After
// reset a sweep sets handle, status and link of all 1024 slots; in_ch.ready is
// low during it. A waiting result does not block the next item from entering;
// only the update step waits for the result register to drain.
module generational_slot_allocator_top
  import gsa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  gsa_in_if.sink    in_ch,
  gsa_out_if.source out_ch
);

  dp_cmd_t   ctl;
  dp_stat_t  stat;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;

  assign in_item.cmd           = in_ch.cmd;
  assign in_item.handle        = in_ch.handle;
  assign in_item.check_perm    = in_ch.check_perm;
  assign in_item.parent_handle = in_ch.parent_handle;
  assign in_item.target_slot   = in_ch.target_slot;
  assign in_ch.ready           = ctl.accept;

  gsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  gsa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_item   (in_item),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .stat      (stat)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.code        = out_item.code;
  assign out_ch.has_slot    = out_item.has_slot;
  assign out_ch.slot_index  = out_item.slot_index;
  assign out_ch.slot_handle = out_item.slot_handle;

endmodule
